// File: sv/software_timer_table_top_macros.svh
// Assertion macros for the timer table top level.
// Needs clk and rst in the scope where a macro is used.
`ifndef SOFTWARE_TIMER_TABLE_TOP_MACROS_SVH
`define SOFTWARE_TIMER_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define STT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/stt_pkg.sv
// Shared types and codes for the timer table.
// No dependencies.
package stt_pkg;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_RUN    = 3'd3;
  localparam logic [2:0] OP_FIND   = 3'd4;

  localparam int IDX_W = 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [7:0]  tid;
    logic [15:0] delay;
    logic [15:0] period;
  } entry_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic slot_act;
    logic cnt_inc;
    logic final_emit;
  } cmd_t;

  typedef struct packed {
    logic op_known;
    logic slot_emit;
    logic slot_end;
    logic cnt_last;
    logic out_free;
  } sts_t;

endpackage

// File: sv/stt_datapath.sv
// Timer table datapath: slot memory, valid bits, scan counter, output word register.
// Depends on stt_pkg; driven by stt_ctrl commands.
module stt_datapath #(
  parameter int SLOTS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  stt_pkg::cmd_t           cmd,
  output stt_pkg::sts_t           sts,
  input  logic [2:0]              operation,
  input  logic [7:0]              task_id,
  input  logic [15:0]             initial_delay,
  input  logic [15:0]             reload_period,
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  output logic [7:0]              fired_id,
  output logic [stt_pkg::IDX_W-1:0] slot_index,
  output logic                    table_full,
  output logic                    match_found,
  output logic [15:0]             remaining_delay,
  output logic [15:0]             period_value,
  output logic                    last
);
  import stt_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  entry_t             mem [SLOTS];
  entry_t             rd_data;
  entry_t             wdata;
  logic [SLOTS-1:0]   valid;
  logic [SLOT_W-1:0]  cnt;
  logic [2:0]         op_q;
  logic [7:0]         id_q;
  logic [15:0]        dly_q;
  logic [15:0]        per_q;
  logic               hit;
  logic               cur_valid;
  logic               match;
  logic               fire;
  logic               slot_emit;
  logic               slot_end;
  logic               we;
  logic               set_v;
  logic               clr_v;
  logic               load_out;

  always_comb begin
    cur_valid = valid[cnt];
    match     = (id_q != 8'd0) && cur_valid && (rd_data.tid == id_q);
    fire      = cur_valid && (rd_data.delay == 16'd0);
    slot_emit = 1'b0;
    slot_end  = 1'b0;
    we        = 1'b0;
    set_v     = 1'b0;
    clr_v     = 1'b0;
    wdata     = rd_data;
    case (op_q)
      OP_TICK: begin
        if (cur_valid && (rd_data.delay != 16'd0)) begin
          we          = 1'b1;
          wdata.delay = rd_data.delay - 16'd1;
        end
      end
      OP_ADD: begin
        if (!cur_valid) begin
          slot_emit = 1'b1;
          slot_end  = 1'b1;
          if (id_q != 8'd0) begin
            we           = 1'b1;
            set_v        = 1'b1;
            wdata.tid    = id_q;
            wdata.delay  = dly_q;
            wdata.period = per_q;
          end
        end
      end
      OP_REMOVE: clr_v = match;
      OP_RUN: begin
        if (fire) begin
          slot_emit = 1'b1;
          if (rd_data.period == 16'd0) begin
            clr_v = 1'b1;
          end else begin
            we          = 1'b1;
            wdata.delay = rd_data.period;
          end
        end
      end
      OP_FIND: begin
        slot_emit = match;
        slot_end  = match;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts.op_known  = op_q inside {[OP_TICK:OP_FIND]};
    sts.slot_emit = slot_emit;
    sts.slot_end  = slot_end;
    sts.cnt_last  = (cnt == SLOT_W'(SLOTS - 1));
    sts.out_free  = !rsp_valid || !rsp_stall;
    load_out      = (cmd.slot_act && slot_emit) || cmd.final_emit;
  end

  always_ff @(posedge clk) begin
    if (cmd.slot_act && we) begin
      mem[cnt] <= wdata;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_q  <= task_id;
      dly_q <= initial_delay;
      per_q <= reload_period;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      cnt   <= '0;
      op_q  <= OP_TICK;
      hit   <= 1'b0;
    end else begin
      if (cmd.load) begin
        op_q <= operation;
        cnt  <= '0;
        hit  <= 1'b0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + SLOT_W'(1);
      end
      if (cmd.slot_act) begin
        if (set_v) valid[cnt] <= 1'b1;
        if (clr_v) valid[cnt] <= 1'b0;
        if ((op_q == OP_REMOVE) && match) hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (cmd.final_emit) begin
        fired_id        <= 8'd0;
        slot_index      <= '0;
        table_full      <= (op_q == OP_ADD);
        match_found     <= (op_q == OP_REMOVE) && hit;
        remaining_delay <= 16'd0;
        period_value    <= 16'd0;
        last            <= 1'b1;
      end else begin
        fired_id        <= (op_q == OP_RUN) ? rd_data.tid : 8'd0;
        slot_index      <= IDX_W'(cnt);
        table_full      <= 1'b0;
        match_found     <= (op_q == OP_FIND);
        remaining_delay <= (op_q == OP_FIND) ? rd_data.delay : 16'd0;
        period_value    <= (op_q == OP_FIND) ? rd_data.period : 16'd0;
        last            <= (op_q != OP_RUN);
      end
    end
  end

endmodule

// File: sv/stt_ctrl.sv
// Timer table controller: sequences accept, per-slot read and evaluate, closing word.
// Depends on stt_pkg; drives stt_datapath.
module stt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  stt_pkg::sts_t sts,
  output stt_pkg::cmd_t cmd
);
  import stt_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = sts.op_known ? ST_EVAL : ST_FINISH;
      end
      ST_EVAL: begin
        if (sts.slot_emit && !sts.out_free) begin
          state_next = ST_EVAL;
        end else if (sts.slot_emit && sts.slot_end) begin
          state_next = ST_IDLE;
        end else if (sts.cnt_last) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        cmd.load  = req_valid;
      end
      ST_READ: cmd.rd_en = sts.op_known;
      ST_EVAL: begin
        cmd.slot_act = !sts.slot_emit || sts.out_free;
        cmd.cnt_inc  = cmd.slot_act && !(sts.slot_emit && sts.slot_end) && !sts.cnt_last;
      end
      ST_FINISH: cmd.final_emit = sts.out_free;
      default: ;
    endcase
  end

endmodule

// File: sv/software_timer_table_top.sv
// Timer table top level: controller plus datapath, with checks.
// Depends on stt_pkg, stt_ctrl, stt_datapath and the assertion macro header.
//
// Usage:
//   Request channel (req_valid / req_stall) takes one operation word:
//   operation, task_id, initial_delay, reload_period. Response channel
//   (rsp_valid / rsp_stall) returns result words; the final word of each
//   request has last set. Run returns one word per fired slot, then a
//   closing word.
//   A request is taken only while no earlier request is in work; the
//   response register keeps the previous final word meanwhile.
//   Sequence: an accept state, then per slot a memory read state and an
//   evaluate-and-write-back state, then a state for the closing word.
//   Add and find stop at the slot that answers; unknown codes skip the
//   slot scan and go straight from the read state to the closing word.
//   The slot scan through the single-port slot memory sets how long a request takes.
//   A stalled response holds the scan at the slot that wants to emit.
//   Reset empties the table at once; slot contents are not cleared.
`include "software_timer_table_top_macros.svh"

module software_timer_table_top #(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  operation,
  input  logic [7:0]  task_id,
  input  logic [15:0] initial_delay,
  input  logic [15:0] reload_period,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [7:0]  fired_id,
  output logic [5:0]  slot_index,
  output logic        table_full,
  output logic        match_found,
  output logic [15:0] remaining_delay,
  output logic [15:0] period_value,
  output logic        last
);
  import stt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  stt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  stt_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .operation       (operation),
    .task_id         (task_id),
    .initial_delay   (initial_delay),
    .reload_period   (reload_period),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .fired_id        (fired_id),
    .slot_index      (slot_index),
    .table_full      (table_full),
    .match_found     (match_found),
    .remaining_delay (remaining_delay),
    .period_value    (period_value),
    .last            (last)
  );

  `STT_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "accept did not start work")
  `STT_ASSERT_NOW(a_emit_into_free, (cmd.slot_act && sts.slot_emit) || cmd.final_emit, sts.out_free, "word written over held response")
  `STT_ASSERT_NEXT(a_idle_after_final, cmd.final_emit, !req_stall, "closing word did not return to idle")
  `STT_ASSERT_NOW(a_final_no_fire, rsp_valid && last, fired_id == 8'd0, "final word carries a fired id")

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for software_timer_table_top: directed and random timer operations.
// Depends on stt_pkg and the timer table RTL; expected words come from an in-bench table model.
`timescale 1ns / 100ps

module tb_top;
  import stt_pkg::*;

  localparam int SLOTS = 8;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_LEN = 400;
  localparam int DRAIN_CYCLES = 2 * SLOTS + 8;

  typedef struct packed {
    logic [7:0]  fired_id;
    logic [5:0]  slot_index;
    logic        table_full;
    logic        match_found;
    logic [15:0] remaining_delay;
    logic [15:0] period_value;
    logic        last;
  } result_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [2:0]  operation = '0;
  logic [7:0]  task_id = '0;
  logic [15:0] initial_delay = '0;
  logic [15:0] reload_period = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [7:0]  fired_id;
  logic [5:0]  slot_index;
  logic        table_full;
  logic        match_found;
  logic [15:0] remaining_delay;
  logic [15:0] period_value;
  logic        last;

  // timer table model
  bit          occ[SLOTS] = '{default: 1'b0};
  logic [7:0]  slot_tid[SLOTS];
  logic [15:0] slot_left[SLOTS];
  logic [15:0] slot_reload[SLOTS];

  result_word_t expected_words[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int quiet_cycles = 0;

  software_timer_table_top #(.SLOTS(SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .operation(operation),
    .task_id(task_id),
    .initial_delay(initial_delay),
    .reload_period(reload_period),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .fired_id(fired_id),
    .slot_index(slot_index),
    .table_full(table_full),
    .match_found(match_found),
    .remaining_delay(remaining_delay),
    .period_value(period_value),
    .last(last)
  );

  always #2 clk = ~clk;

  function automatic void apply_timer_op(logic [2:0] op, logic [7:0] id, logic [15:0] dly,
                                         logic [15:0] per);
    result_word_t r;
    int free_slot;
    bit hit;
    r = '0;
    r.last = 1'b1;
    free_slot = -1;
    hit = 1'b0;
    case (op)
      OP_TICK: begin
        for (int i = 0; i < SLOTS; i++)
          if (occ[i] && slot_left[i] != 16'd0) slot_left[i] = slot_left[i] - 16'd1;
      end
      OP_ADD: begin
        for (int i = SLOTS - 1; i >= 0; i--)
          if (!occ[i]) free_slot = i;
        if (free_slot < 0) begin
          r.table_full = 1'b1;
        end else begin
          r.slot_index = 6'(free_slot);
          if (id != 8'd0) begin
            occ[free_slot] = 1'b1;
            slot_tid[free_slot] = id;
            slot_left[free_slot] = dly;
            slot_reload[free_slot] = per;
          end
        end
      end
      OP_REMOVE: begin
        for (int i = 0; i < SLOTS; i++)
          if (id != 8'd0 && occ[i] && slot_tid[i] == id) begin
            occ[i] = 1'b0;
            hit = 1'b1;
          end
        r.match_found = hit;
      end
      OP_RUN: begin
        for (int i = 0; i < SLOTS; i++)
          if (occ[i] && slot_left[i] == 16'd0) begin
            result_word_t f;
            f = '0;
            f.fired_id = slot_tid[i];
            f.slot_index = 6'(i);
            expected_words.push_back(f);
            if (slot_reload[i] == 16'd0) occ[i] = 1'b0;
            else slot_left[i] = slot_reload[i];
          end
      end
      OP_FIND: begin
        for (int i = 0; i < SLOTS; i++)
          if (!hit && id != 8'd0 && occ[i] && slot_tid[i] == id) begin
            hit = 1'b1;
            r.match_found = 1'b1;
            r.slot_index = 6'(i);
            r.remaining_delay = slot_left[i];
            r.period_value = slot_reload[i];
          end
      end
      default: ;
    endcase
    expected_words.push_back(r);
  endfunction

  task automatic send_word(logic [2:0] op, logic [7:0] id, logic [15:0] dly, logic [15:0] per);
    if ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    req_valid <= 1'b1;
    operation <= op;
    task_id <= id;
    initial_delay <= dly;
    reload_period <= per;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    apply_timer_op(op, id, dly, per);
  endtask

  function automatic void random_word(output logic [2:0] op, output logic [7:0] id,
                                      output logic [15:0] dly, output logic [15:0] per);
    int r;
    int used;
    int add_top;
    int pick;
    used = 0;
    foreach (occ[i]) used += occ[i];
    add_top = (used >= SLOTS - 1) ? 38 : 52;
    r = $urandom_range(99);
    if (r < 30) op = OP_TICK;
    else if (r < add_top) op = OP_ADD;
    else if (r < 64) op = OP_REMOVE;
    else if (r < 84) op = OP_RUN;
    else if (r < 97) op = OP_FIND;
    else op = 3'($urandom_range(7, OP_FIND + 1));

    r = $urandom_range(99);
    if (r < 8) id = 8'd0;
    else if (r < 30) id = 8'($urandom_range(255, 1));
    else id = 8'($urandom_range(12, 1));
    if ((op == OP_REMOVE || op == OP_FIND) && $urandom_range(99) < 60) begin
      pick = $urandom_range(SLOTS - 1);
      if (occ[pick]) id = slot_tid[pick];
    end

    r = $urandom_range(99);
    if (r < 60) dly = 16'($urandom_range(4));
    else if (r < 85) dly = 16'($urandom_range(30));
    else dly = 16'($urandom_range(65535));

    r = $urandom_range(99);
    if (r < 35) per = 16'd0;
    else if (r < 80) per = 16'($urandom_range(6, 1));
    else per = 16'($urandom_range(65535));
  endfunction

  task automatic test_directed();
    idle_pct = 0;
    stall_pct = 0;
    // empty table
    send_word(OP_FIND, 8'h05, 16'h0000, 16'h0000);
    send_word(OP_RUN, 8'h00, 16'h0000, 16'h0000);
    send_word(OP_TICK, 8'h00, 16'h0000, 16'h0000);
    send_word(OP_REMOVE, 8'h05, 16'h0000, 16'h0000);
    // id zero reports a slot but leaves it free
    send_word(OP_ADD, 8'h00, 16'h0003, 16'h0003);
    // fill every slot already expired, duplicate id included
    send_word(OP_ADD, 8'hFF, 16'h0000, 16'hFFFF);
    send_word(OP_ADD, 8'h01, 16'h0000, 16'h0000);
    send_word(OP_ADD, 8'hAA, 16'h0000, 16'h0000);
    send_word(OP_ADD, 8'h55, 16'h0000, 16'h0003);
    send_word(OP_ADD, 8'h55, 16'h0000, 16'h0000);
    send_word(OP_ADD, 8'h80, 16'h0000, 16'h5555);
    send_word(OP_ADD, 8'h7F, 16'h0000, 16'hAAAA);
    send_word(OP_ADD, 8'h02, 16'h0000, 16'h0001);
    send_word(OP_ADD, 8'h10, 16'h0001, 16'h0001);
    send_word(OP_ADD, 8'h00, 16'h0001, 16'h0001);
    send_word(OP_FIND, 8'h55, 16'h0000, 16'h0000);
    send_word(OP_FIND, 8'h00, 16'h0000, 16'h0000);
    // all eight fire
    send_word(OP_RUN, 8'h00, 16'h0000, 16'h0000);
    send_word(OP_ADD, 8'h33, 16'hFFFF, 16'hAAAA);
    send_word(OP_TICK, 8'h00, 16'h0000, 16'h0000);
    send_word(OP_RUN, 8'h00, 16'h0000, 16'h0000);
    for (int c = OP_FIND + 1; c < 8; c++) send_word(3'(c), 8'hAA, 16'hFFFF, 16'hFFFF);
    send_word(OP_REMOVE, 8'h00, 16'h0000, 16'h0000);
    send_word(OP_REMOVE, 8'h55, 16'h0000, 16'h0000);
    send_word(OP_FIND, 8'hFF, 16'h0000, 16'h0000);
    send_word(OP_RUN, 8'h00, 16'h0000, 16'h0000);
  endtask

  task automatic test_random_traffic(int n, int sender_idle, int receiver_stall);
    logic [2:0]  op;
    logic [7:0]  id;
    logic [15:0] dly;
    logic [15:0] per;
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    repeat (n) begin
      random_word(op, id, dly, per);
      send_word(op, id, dly, per);
    end
  endtask

  // response side held off while requests keep coming
  task automatic test_backpressure();
    logic [2:0]  op;
    logic [7:0]  id;
    logic [15:0] dly;
    logic [15:0] per;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    repeat (16) begin
      random_word(op, id, dly, per);
      send_word(op, id, dly, per);
    end
    hold_req = 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_req && hold_cnt < HOLD_LEN) begin
      rsp_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!hold_req) hold_cnt <= 0;
    end
  end

  function automatic void cmp_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    result_word_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_words.size() == 0) begin
        $error("result word with none expected: fired_id 0x%0h slot %0d", fired_id, slot_index);
        errors++;
      end else begin
        e = expected_words.pop_front();
        cmp_field("fired_id", 16'(e.fired_id), 16'(fired_id));
        cmp_field("slot_index", 16'(e.slot_index), 16'(slot_index));
        cmp_field("table_full", 16'(e.table_full), 16'(table_full));
        cmp_field("match_found", 16'(e.match_found), 16'(match_found));
        cmp_field("remaining_delay", e.remaining_delay, remaining_delay);
        cmp_field("period_value", e.period_value, period_value);
        cmp_field("last", 16'(e.last), 16'(last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_traffic(95, 0, 0);
    test_random_traffic(95, 81, 0);
    test_random_traffic(95, 0, 81);
    test_random_traffic(95, 33, 33);
    test_backpressure();
    req_valid <= 1'b0;
    stall_pct = 0;
    while (expected_words.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
